[hw/rtl/bpc_pkg.sv]
// shared types, constants and helper functions for the barometric compensation block
`default_nettype none
package bpc_pkg;

  localparam int RAW_W  = 24;
  localparam int TEMP_W = 24;
  localparam int PRES_W = 23;
  localparam int ACC_W  = 128;
  localparam int LIMB_W = 32;
  localparam int Y_W    = 25;
  localparam int PP_W   = 58;
  localparam int CFG_W  = 48;
  localparam int IDX_W  = 3;
  localparam int OUT_SHIFT = 79;
  localparam int PFL_W  = ACC_W - OUT_SHIFT;

  localparam logic signed [31:0] TEMP_MIN = -32'sd2621440;
  localparam logic signed [31:0] TEMP_MAX = 32'sd5570560;
  localparam logic signed [PFL_W-1:0] PRESS_MIN = 49'sd1920000;
  localparam logic signed [PFL_W-1:0] PRESS_MAX = 49'sd8000000;
  localparam logic signed [16:0] P_OFFSET = 17'sd16384;

  localparam logic [IDX_W-1:0] CFG_TEMP   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_PRES_A = 3'd1;
  localparam logic [IDX_W-1:0] CFG_PRES_B = 3'd2;
  localparam logic [IDX_W-1:0] CFG_PRES_C = 3'd3;

  localparam logic [3:0] U_LAST = 4'd13;

  typedef struct packed {
    logic [RAW_W-1:0]         press;
    logic signed [TEMP_W-1:0] temp;
    logic                     tclamp;
  } item_t;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_OUT} back_state_t;
  typedef enum logic {OP_LOAD, OP_MAC} op_t;
  typedef enum logic [1:0] {SV_NONE, SV_C0, SV_C1, SV_C2} save_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] nlimb;
    logic       use_p;
    save_t      save;
  } ucode_t;

  // horner sequence: c1 and c0 in temperature, c2, then the polynomial in raw pressure
  function automatic ucode_t ucode(logic [3:0] u);
    ucode_t c;
    c = '{op: OP_LOAD, nlimb: 2'd1, use_p: 1'b0, save: SV_NONE};
    case (u)
      4'd0, 4'd4, 4'd8, 4'd10: c.op = OP_LOAD;
      4'd1, 4'd2, 4'd5: c = '{op: OP_MAC, nlimb: 2'd1, use_p: 1'b0, save: SV_NONE};
      4'd3:  c = '{op: OP_MAC, nlimb: 2'd2, use_p: 1'b0, save: SV_C1};
      4'd6:  c = '{op: OP_MAC, nlimb: 2'd2, use_p: 1'b0, save: SV_NONE};
      4'd7:  c = '{op: OP_MAC, nlimb: 2'd3, use_p: 1'b0, save: SV_C0};
      4'd9:  c = '{op: OP_MAC, nlimb: 2'd1, use_p: 1'b0, save: SV_C2};
      4'd11: c = '{op: OP_MAC, nlimb: 2'd1, use_p: 1'b1, save: SV_NONE};
      4'd12: c = '{op: OP_MAC, nlimb: 2'd2, use_p: 1'b1, save: SV_NONE};
      4'd13: c = '{op: OP_MAC, nlimb: 2'd3, use_p: 1'b1, save: SV_NONE};
      default: c.op = OP_LOAD;
    endcase
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] sx8(logic [7:0] v);
    return {{(ACC_W-8){v[7]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sx16(logic [15:0] v);
    return {{(ACC_W-16){v[15]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sx17(logic [16:0] v);
    return {{(ACC_W-17){v[16]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] zx16(logic [15:0] v);
    return {{(ACC_W-16){1'b0}}, v};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bpc_front.sv]
// front pipeline: takes a word and computes the clamped temperature
`default_nettype none
module bpc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bpc_pkg::RAW_W-1:0]     in_raw_pressure,
  input  wire logic [bpc_pkg::RAW_W-1:0]     in_raw_temperature,
  input  wire logic [39:0]                   temp_calib,
  output logic                               push,
  output bpc_pkg::item_t                     push_item,
  input  wire logic                          q_full
);

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  logic [bpc_pkg::RAW_W-1:0] p1_r, p2_r, p3_r;
  logic signed [24:0] d_r;
  logic signed [41:0] m1_r, m1b_r;
  logic signed [49:0] dd_r;
  logic signed [57:0] m2_r;
  bpc_pkg::item_t item_r;

  logic signed [24:0] d_nxt;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3s;
  logic signed [63:0] tn;
  logic signed [31:0] t16;
  bpc_pkg::item_t item_nxt;

  assign adv      = !v4_r || !q_full;
  assign in_stall = !adv;
  assign push     = v4_r && !q_full;
  assign push_item = item_r;

  assign t2s = $signed({1'b0, temp_calib[31:16]});
  assign t3s = $signed(temp_calib[39:32]);
  assign d_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, temp_calib[15:0], 8'd0});

  always_comb begin
    tn  = ({{22{m1b_r[41]}}, m1b_r} <<< 18) + {{6{m2_r[57]}}, m2_r};
    t16 = tn[63:32];
    item_nxt.press  = p3_r;
    item_nxt.tclamp = 1'b0;
    item_nxt.temp   = t16[bpc_pkg::TEMP_W-1:0];
    if (t16 < bpc_pkg::TEMP_MIN) begin
      item_nxt.temp   = bpc_pkg::TEMP_MIN[bpc_pkg::TEMP_W-1:0];
      item_nxt.tclamp = 1'b1;
    end else if (t16 > bpc_pkg::TEMP_MAX) begin
      item_nxt.temp   = bpc_pkg::TEMP_MAX[bpc_pkg::TEMP_W-1:0];
      item_nxt.tclamp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= in_raw_pressure;
      d_r    <= d_nxt;
      p2_r   <= p1_r;
      m1_r   <= d_r * t2s;
      dd_r   <= d_r * d_r;
      p3_r   <= p2_r;
      m1b_r  <= m1_r;
      m2_r   <= dd_r * t3s;
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bpc_queue.sv]
// two-entry queue between the temperature front and the pressure back
`default_nettype none
module bpc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bpc_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output bpc_pkg::item_t      head
);

  bpc_pkg::item_t mem_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

[hw/rtl/bpc_back.sv]
// back end: sequenced multiply-accumulate over limbs for the pressure polynomial
`default_nettype none
module bpc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire bpc_pkg::item_t               q_head,
  output logic                              pop,
  input  wire logic [47:0]                  press_calib_a,
  input  wire logic [47:0]                  press_calib_b,
  input  wire logic [31:0]                  press_calib_c,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [bpc_pkg::TEMP_W-1:0] out_temperature_out,
  output logic [bpc_pkg::PRES_W-1:0]        out_pressure_out,
  output logic                              out_temp_clamped,
  output logic                              out_press_clamped
);

  bpc_pkg::back_state_t state_r, state_nxt;
  logic [3:0] u_r;
  logic [1:0] li_r, ppidx_r;
  logic [bpc_pkg::RAW_W-1:0] press_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp_r;
  logic tc_r;
  logic signed [bpc_pkg::ACC_W-1:0] acc_r, sum_r, c0_r, c1_r, c2_r;
  logic signed [bpc_pkg::PP_W-1:0] pp_r;
  logic out_valid_r;
  logic signed [bpc_pkg::TEMP_W-1:0] out_temp_r;
  logic [bpc_pkg::PRES_W-1:0] out_pres_r;
  logic out_tc_r, out_pc_r;

  bpc_pkg::ucode_t uc;
  logic signed [bpc_pkg::ACC_W-1:0] k;
  logic signed [bpc_pkg::ACC_W-1:0] pp_sh, sum_nxt;
  logic [bpc_pkg::LIMB_W-1:0] limb;
  logic signed [bpc_pkg::LIMB_W:0] limb_s;
  logic signed [bpc_pkg::Y_W-1:0] y;
  logic mac_last, step_done, out_load;
  logic signed [bpc_pkg::PFL_W-1:0] pfl;
  logic [bpc_pkg::PRES_W-1:0] pres_c;
  logic pc;

  assign uc = bpc_pkg::ucode(u_r);

  always_comb begin
    case (u_r)
      4'd0:  k = bpc_pkg::sx8(press_calib_a[47:40]);
      4'd1:  k = bpc_pkg::sx8(press_calib_a[39:32]) <<< 21;
      4'd2:  k = bpc_pkg::sx17({press_calib_a[31], press_calib_a[31:16]} - bpc_pkg::P_OFFSET) <<< 40;
      4'd3:  k = bpc_pkg::sx17({press_calib_a[15], press_calib_a[15:0]} - bpc_pkg::P_OFFSET) <<< 65;
      4'd4:  k = bpc_pkg::sx8(press_calib_b[47:40]) <<< 22;
      4'd5:  k = bpc_pkg::sx8(press_calib_b[39:32]) <<< 45;
      4'd6:  k = bpc_pkg::zx16(press_calib_b[31:16]) <<< 63;
      4'd7:  k = bpc_pkg::zx16(press_calib_b[15:0]) <<< 88;
      4'd8:  k = bpc_pkg::sx8(press_calib_c[23:16]) <<< 21;
      4'd9:  k = bpc_pkg::sx16(press_calib_c[15:0]) <<< 37;
      4'd10: k = bpc_pkg::sx8(press_calib_c[31:24]) <<< 20;
      4'd11: k = c2_r;
      4'd12: k = c1_r;
      4'd13: k = c0_r;
      default: k = '0;
    endcase
  end

  // one 32-bit limb of the accumulator per cycle, top limb carries the sign
  always_comb begin
    limb   = acc_r[{li_r, 5'd0} +: bpc_pkg::LIMB_W];
    limb_s = $signed({(li_r == uc.nlimb - 2'd1) ? limb[bpc_pkg::LIMB_W-1] : 1'b0, limb});
    y      = uc.use_p ? $signed({1'b0, press_r}) : $signed({temp_r[bpc_pkg::TEMP_W-1], temp_r});
    pp_sh  = {{(bpc_pkg::ACC_W-bpc_pkg::PP_W){pp_r[bpc_pkg::PP_W-1]}}, pp_r} <<< {ppidx_r, 5'd0};
    sum_nxt = (li_r == 2'd0) ? k : sum_r + pp_sh;
    mac_last = (li_r == uc.nlimb);
    step_done = (state_r == bpc_pkg::B_RUN) && ((uc.op == bpc_pkg::OP_LOAD) || mac_last);
  end

  always_comb begin
    pfl    = acc_r[bpc_pkg::ACC_W-1:bpc_pkg::OUT_SHIFT];
    pres_c = pfl[bpc_pkg::PRES_W-1:0];
    pc     = 1'b0;
    if (pfl < bpc_pkg::PRESS_MIN) begin
      pres_c = bpc_pkg::PRESS_MIN[bpc_pkg::PRES_W-1:0];
      pc     = 1'b1;
    end else if (pfl > bpc_pkg::PRESS_MAX) begin
      pres_c = bpc_pkg::PRESS_MAX[bpc_pkg::PRES_W-1:0];
      pc     = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpc_pkg::B_IDLE: if (!q_empty) state_nxt = bpc_pkg::B_RUN;
      bpc_pkg::B_RUN:  if (step_done && u_r == bpc_pkg::U_LAST) state_nxt = bpc_pkg::B_OUT;
      bpc_pkg::B_OUT:  if (!out_valid_r || !out_stall) state_nxt = bpc_pkg::B_IDLE;
      default:         state_nxt = bpc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      bpc_pkg::B_IDLE: pop = !q_empty;
      bpc_pkg::B_OUT:  out_load = !out_valid_r || !out_stall;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpc_pkg::B_IDLE;
      u_r         <= 4'd0;
      li_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        u_r  <= 4'd0;
        li_r <= 2'd0;
      end else if (step_done) begin
        u_r  <= u_r + 4'd1;
        li_r <= 2'd0;
      end else if (state_r == bpc_pkg::B_RUN) begin
        li_r <= li_r + 2'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      press_r <= q_head.press;
      temp_r  <= q_head.temp;
      tc_r    <= q_head.tclamp;
    end
    if (state_r == bpc_pkg::B_RUN) begin
      if (uc.op == bpc_pkg::OP_LOAD) begin
        acc_r <= k;
      end else begin
        sum_r   <= sum_nxt;
        pp_r    <= limb_s * y;
        ppidx_r <= li_r;
        if (mac_last) begin
          acc_r <= sum_nxt;
          case (uc.save)
            bpc_pkg::SV_C0: c0_r <= sum_nxt;
            bpc_pkg::SV_C1: c1_r <= sum_nxt;
            bpc_pkg::SV_C2: c2_r <= sum_nxt;
            default: ;
          endcase
        end
      end
    end
    if (out_load) begin
      out_temp_r <= temp_r;
      out_pres_r <= pres_c;
      out_tc_r   <= tc_r;
      out_pc_r   <= pc;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature_out = out_temp_r;
  assign out_pressure_out    = out_pres_r;
  assign out_temp_clamped    = out_tc_r;
  assign out_press_clamped   = out_pc_r;

endmodule
`default_nettype wire

[hw/rtl/baro_pressure_temp_compensation.sv]
// Barometric temperature and pressure compensation. A four-stage front pipeline takes one
// word per cycle while not stalled and forms the clamped temperature; a two-entry queue
// hands it to the back end, which evaluates the pressure polynomial with one 33x25
// multiplier stepped over 32-bit limbs of a 128-bit accumulator. The back end fetches a
// word, runs the multiply-accumulate sequence and hands over the result before it takes
// the next word, which sets the sustained rate. Calibration words may be written only while
// no word is in flight; writes to an index above 3 are ignored.
`default_nettype none
module baro_pressure_temp_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [23:0]                   in_raw_pressure,
  input  wire logic [23:0]                   in_raw_temperature,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [23:0]                 out_temperature_out,
  output logic [22:0]                        out_pressure_out,
  output logic                               out_temp_clamped,
  output logic                               out_press_clamped,
  input  wire logic                          cfg_we,
  input  wire logic [bpc_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

  logic [39:0] temp_calib_r;
  logic [47:0] press_calib_a_r, press_calib_b_r;
  logic [31:0] press_calib_c_r;

  logic push, q_full, q_empty, pop;
  bpc_pkg::item_t push_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r    <= '0;
      press_calib_a_r <= '0;
      press_calib_b_r <= '0;
      press_calib_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::CFG_TEMP:   temp_calib_r    <= cfg_data[39:0];
        bpc_pkg::CFG_PRES_A: press_calib_a_r <= cfg_data;
        bpc_pkg::CFG_PRES_B: press_calib_b_r <= cfg_data;
        bpc_pkg::CFG_PRES_C: press_calib_c_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .temp_calib         (temp_calib_r),
    .push               (push),
    .push_item          (push_item),
    .q_full             (q_full)
  );

  bpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  bpc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .pop                 (pop),
    .press_calib_a       (press_calib_a_r),
    .press_calib_b       (press_calib_b_r),
    .press_calib_c       (press_calib_c_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_temperature_out (out_temperature_out),
    .out_pressure_out    (out_pressure_out),
    .out_temp_clamped    (out_temp_clamped),
    .out_press_clamped   (out_press_clamped)
  );

  a_temp_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_temp_clamped |->
      out_temperature_out == -24'sd2621440 || out_temperature_out == 24'sd5570560)
    else $error("temperature flagged but not at a limit");

  a_press_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_clamped |->
      out_pressure_out == 23'd1920000 || out_pressure_out == 23'd8000000)
    else $error("pressure flagged but not at a limit");

  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pressure_out >= 23'd1920000 && out_pressure_out <= 23'd8000000)
    else $error("pressure out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire
